/* design/rgb2yuv_pkg.sv */
package rgb2yuv_pkg;

    // Widths of the configuration registers, the clamp arithmetic, the register index and the pixel indexes.
    localparam int DIM_W = 13;
    localparam int CMP_W = 14;
    localparam int CFG_INDEX_W = 2;
    localparam int LUMA_INDEX_W = 24;
    localparam int CHROMA_INDEX_W = 22;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 13'd480;
    localparam logic [CMP_W-1:0] FRAME_WIDTH_MIN    = 14'd2;
    localparam logic [CMP_W-1:0] FRAME_HEIGHT_MIN   = 14'd1;

    // BT.601 integer coefficients, scaled by 256.
    localparam logic signed [8:0] Y_R  = 9'sd66;
    localparam logic signed [8:0] Y_G  = 9'sd129;
    localparam logic signed [8:0] Y_B  = 9'sd25;
    localparam logic signed [8:0] CB_R = -9'sd38;
    localparam logic signed [8:0] CB_G = -9'sd74;
    localparam logic signed [8:0] CB_B = 9'sd112;
    localparam logic signed [8:0] CR_R = 9'sd112;
    localparam logic signed [8:0] CR_G = -9'sd94;
    localparam logic signed [8:0] CR_B = -9'sd18;
    localparam logic [7:0] LUMA_OFFSET   = 8'd16;
    localparam logic [7:0] CHROMA_OFFSET = 8'd128;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [7:0]                luma;
        logic [LUMA_INDEX_W-1:0]   luma_index;
        logic                      chroma_valid;
        logic [7:0]                blue_diff;
        logic [7:0]                red_diff;
        logic [CHROMA_INDEX_W-1:0] chroma_index;
        logic                      frame_end;
    } result_t;

    // One classified pixel, as it waits between the front and the back.
    typedef struct packed {
        pixel_t                    pix;
        logic [LUMA_INDEX_W-1:0]   luma_index;
        logic                      chroma_valid;
        logic [CHROMA_INDEX_W-1:0] chroma_index;
        logic                      frame_end;
    } job_t;

endpackage

/* design/rgb_to_yuv420_converter.sv */
// Path: an accepted pixel request is written into the two-entry queue, then popped into
// the output result register, from which the result is valid.
// Throughput: one pixel per clock while result_stall is low; the counters in the front
// and the single arithmetic stage in the back each handle one pixel a cycle.
// Reset (rst_n, asynchronous, active low) clears the position counters and the queue,
// and loads frame_width with 640 and frame_height with 480.
module rgb_to_yuv420_converter
    import rgb2yuv_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration writes take effect at once; the counters are kept.
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]       cfg_data,
    // Pixel requests in raster order.
    input  logic                   pixel_valid,
    output logic                   pixel_stall,
    input  pixel_t                 pixel,
    // One result request per pixel.
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result
);

    // The front tracks column, row, luma and chroma positions, classifies every
    // pixel (chroma sample or not, last of the frame) and pushes it into a
    // two-entry queue. The back pops the queue, computes Y, Cb and Cr and holds
    // the result in an output register. The queue lets the front keep taking
    // pixels while a finished result waits to be taken.

    logic push;
    logic pop;
    logic queue_full;
    logic head_valid;
    job_t push_job;
    job_t head_job;

    assign pixel_stall = queue_full;

    rgb2yuv_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel        (pixel),
        .queue_full   (queue_full),
        .push         (push),
        .job          (push_job)
    );

    rgb2yuv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    rgb2yuv_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_job     (head_job),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

/* design/rgb2yuv_front.sv */
module rgb2yuv_front
    import rgb2yuv_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]       cfg_data,
    input  logic                   pixel_valid,
    input  pixel_t                 pixel,
    input  logic                   queue_full,
    output logic                   push,
    output job_t                   job
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [DIM_W-1:0]          frame_width_reg;
    logic [DIM_W-1:0]          frame_height_reg;
    logic [CW-1:0]             column_count_reg, column_count_next;
    logic [RW-1:0]             row_count_reg, row_count_next;
    logic [LUMA_INDEX_W-1:0]   pixel_count_reg, pixel_count_next;
    logic [CHROMA_INDEX_W-1:0] chroma_count_reg, chroma_count_next;

    logic [CMP_W-1:0] width_raw, height_raw, width_eff, height_eff;
    logic             chroma, row_last, frame_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_write_en)
        begin
            if (cfg_index == REG_FRAME_WIDTH)
            begin
                frame_width_reg <= cfg_data;
            end
            else if (cfg_index == REG_FRAME_HEIGHT)
            begin
                frame_height_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        width_raw  = CMP_W'(frame_width_reg);
        height_raw = CMP_W'(frame_height_reg);
        if (width_raw < FRAME_WIDTH_MIN)
            width_eff = FRAME_WIDTH_MIN;
        else if (width_raw > CMP_W'(MAX_WIDTH))
            width_eff = CMP_W'(MAX_WIDTH);
        else
            width_eff = width_raw;
        if (height_raw < FRAME_HEIGHT_MIN)
            height_eff = FRAME_HEIGHT_MIN;
        else if (height_raw > CMP_W'(MAX_HEIGHT))
            height_eff = CMP_W'(MAX_HEIGHT);
        else
            height_eff = height_raw;

        chroma     = !row_count_reg[0] && !column_count_reg[0];
        row_last   = (CMP_W'(column_count_reg) + CMP_W'(1)) >= width_eff;
        frame_last = row_last && ((CMP_W'(row_count_reg) + CMP_W'(1)) >= height_eff);
    end

    assign push = pixel_valid && !queue_full;

    always_comb
    begin
        job.pix          = pixel;
        job.luma_index   = pixel_count_reg;
        job.chroma_valid = chroma;
        job.chroma_index = chroma ? chroma_count_reg : '0;
        job.frame_end    = frame_last;
    end

    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        pixel_count_next  = pixel_count_reg;
        chroma_count_next = chroma_count_reg;
        if (push)
        begin
            if (frame_last)
            begin
                column_count_next = '0;
                row_count_next    = '0;
                pixel_count_next  = '0;
                chroma_count_next = '0;
            end
            else
            begin
                pixel_count_next = pixel_count_reg + LUMA_INDEX_W'(1);
                if (chroma)
                    chroma_count_next = chroma_count_reg + CHROMA_INDEX_W'(1);
                if (row_last)
                begin
                    column_count_next = '0;
                    row_count_next    = row_count_reg + RW'(1);
                end
                else
                begin
                    column_count_next = column_count_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            pixel_count_reg  <= '0;
            chroma_count_reg <= '0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            pixel_count_reg  <= pixel_count_next;
            chroma_count_reg <= chroma_count_next;
        end
    end

endmodule

/* design/rgb2yuv_queue.sv */
module rgb2yuv_queue
    import rgb2yuv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head_job   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* design/rgb2yuv_back.sv */
module rgb2yuv_back
    import rgb2yuv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    head_valid,
    input  job_t    head_job,
    output logic    pop,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic    valid_reg, valid_next;
    result_t result_reg;
    result_t computed;

    logic signed [17:0] r, g, b;
    logic signed [17:0] y_sum, cb_sum, cr_sum;

    assign pop = head_valid && (!valid_reg || !result_stall);

    always_comb
    begin
        r = $signed({10'd0, head_job.pix.red});
        g = $signed({10'd0, head_job.pix.green});
        b = $signed({10'd0, head_job.pix.blue});

        y_sum  = 18'(Y_R * r) + 18'(Y_G * g) + 18'(Y_B * b);
        cb_sum = 18'(CB_R * r) + 18'(CB_G * g) + 18'(CB_B * b);
        cr_sum = 18'(CR_R * r) + 18'(CR_G * g) + 18'(CR_B * b);

        // Bits 15:8 are the floor of the sum over 256, kept modulo 256.
        computed.luma         = y_sum[15:8] + LUMA_OFFSET;
        computed.luma_index   = head_job.luma_index;
        computed.chroma_valid = head_job.chroma_valid;
        computed.blue_diff    = head_job.chroma_valid ? (cb_sum[15:8] + CHROMA_OFFSET) : '0;
        computed.red_diff     = head_job.chroma_valid ? (cr_sum[15:8] + CHROMA_OFFSET) : '0;
        computed.chroma_index = head_job.chroma_index;
        computed.frame_end    = head_job.frame_end;
    end

    always_comb
    begin
        if (pop)
            valid_next = 1'b1;
        else if (result_stall)
            valid_next = valid_reg;
        else
            valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= computed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule
